// ===== src/dnp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnp_pkg: shared types and constants of the dotted network number parser
// Character codes, the classified token that crosses the queue, and the
// parse phase and number base encodings.
// ----------------------------------------------------------------------------
package dnp_pkg;

	localparam int CHAR_W          = 8;
	localparam int NET_W           = 32;
	localparam int CNT_W           = 3;
	localparam int ACC_W           = 9;
	localparam int DIGIT_W         = 4;
	localparam int PROD_W          = 13;
	localparam int OUT_TDATA_W     = 40;
	localparam int MAX_PARTS_DEF   = 4;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [ACC_W-1:0]  ACC_SAT  = 9'h100;
	localparam logic [CHAR_W-1:0] BYTE_MAX = 8'hff;
	localparam logic [NET_W-1:0]  NET_ERR  = 32'hffff_ffff;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_F_UP  = 8'h46;
	localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
	localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_F_LO  = 8'h66;
	localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;

	localparam logic [DIGIT_W-1:0] HEX_LETTER_OFS = 4'd9;

	// classified character
	typedef struct packed {
		logic               term;   // zero byte
		logic               dot;
		logic               space;
		logic               zero;   // the character '0'
		logic               x;      // 'x' or 'X'
		logic               dec;    // '0' to '9'
		logic               hexl;   // 'a'..'f' or 'A'..'F'
		logic [DIGIT_W-1:0] digit;  // digit value when dec or hexl
	} dnp_token_t;

	typedef struct packed {
		logic full;
		logic empty;
	} dnp_qstat_t;

	typedef enum logic [1:0] {
		PH_START,
		PH_ZERO,
		PH_DIGITS
	} dnp_phase_t;

	typedef enum logic [1:0] {
		BASE_DEC,
		BASE_OCT,
		BASE_HEX
	} dnp_base_t;

endpackage

// ===== src/dnp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnp_front: input side of the parser
// Accepts characters and classifies each into a token for the queue.
// ----------------------------------------------------------------------------
module dnp_front
	import dnp_pkg::*;
(
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [CHAR_W-1:0] s_tdata,   // [7:0] char_code
	input  dnp_qstat_t        qstat,
	output logic              push,
	output dnp_token_t        token
);

	logic [CHAR_W-1:0] c;

	assign c        = s_tdata;
	assign s_tready = !qstat.full;
	assign push     = s_tvalid && !qstat.full;

	always_comb begin
		logic lower_hex;
		logic upper_hex;
		lower_hex   = (c >= CH_A_LO) && (c <= CH_F_LO);
		upper_hex   = (c >= CH_A_UP) && (c <= CH_F_UP);
		token.term  = (c == CH_NUL);
		token.dot   = (c == CH_DOT);
		token.space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
		token.zero  = (c == CH_ZERO);
		token.x     = (c == CH_X_LO) || (c == CH_X_UP);
		token.dec   = (c >= CH_ZERO) && (c <= CH_NINE);
		token.hexl  = lower_hex || upper_hex;
		// letters: low nibble 1..6 maps to 10..15
		token.digit = token.dec ? c[DIGIT_W-1:0] : DIGIT_W'(c[DIGIT_W-1:0] + HEX_LETTER_OFS);
	end

endmodule

// ===== src/dnp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnp_queue: token queue between front and back
// Small register FIFO, head visible the cycle after a write.
// ----------------------------------------------------------------------------
module dnp_queue
	import dnp_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF   // power of two, at least 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  dnp_token_t push_tok,
	input  logic       pop,
	output dnp_token_t head_tok,
	output dnp_qstat_t qstat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_QW = $clog2(DEPTH + 1);

	dnp_token_t        mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;

	assign head_tok    = mem_q[rd_ptr_q];
	assign qstat.full  = (count_q == CNT_QW'(DEPTH));
	assign qstat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			case ({push, pop})
				2'b10:   count_q <= CNT_QW'(count_q + 1'b1);
				2'b01:   count_q <= CNT_QW'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/dnp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnp_back: parse engine and result register
// Takes one token a cycle unless a zero byte waits; keeps part state, emits at it.
// ----------------------------------------------------------------------------
module dnp_back
	import dnp_pkg::*;
#(
	parameter int MAX_PARTS = MAX_PARTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dnp_token_t             head_tok,
	input  dnp_qstat_t             qstat,
	output logic                   pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] net_value, [34:32] part_count
	output logic                   m_tuser    // [0] valid_res
);

	// earlier parts packed; a valid result never holds more than MAX_PARTS-1
	localparam int PACK_W = (MAX_PARTS > 1) ? 8 * (MAX_PARTS - 1) : 8;

	dnp_phase_t         phase_q, phase_n;
	dnp_base_t          base_q, base_n;
	logic [ACC_W-1:0]   acc_q, acc_n;
	logic               seen_q, seen_n;
	logic [CNT_W-1:0]   parts_q, parts_n;
	logic [PACK_W-1:0]  pack_q, pack_n;
	logic               err_q, err_n;
	logic               skip_q, skip_n;

	logic               out_valid_q;
	logic               res_valid_q;
	logic [NET_W-1:0]   res_net_q;
	logic [CNT_W-1:0]   res_cnt_q;

	logic               out_free;
	logic [PROD_W-1:0]  acc_ext, prod, sum;
	logic [ACC_W-1:0]   acc_step;
	logic               part_ok;
	logic               term_ok;
	logic [PACK_W+7:0]  joined;

	assign out_free = !out_valid_q || m_tready;
	assign pop      = !qstat.empty && (!head_tok.term || out_free);

	// accumulate by the current base
	always_comb begin
		acc_ext = PROD_W'(acc_q);
		case (base_q)
			BASE_OCT: prod = acc_ext << 3;
			BASE_HEX: prod = acc_ext << 4;
			default:  prod = PROD_W'((acc_ext << 3) + (acc_ext << 1));
		endcase
		sum      = PROD_W'(prod + PROD_W'(head_tok.digit));
		acc_step = (sum > PROD_W'(BYTE_MAX)) ? ACC_SAT : sum[ACC_W-1:0];
	end

	assign part_ok = seen_q && (parts_q < CNT_W'(MAX_PARTS)) && (acc_q <= ACC_W'(BYTE_MAX));
	assign term_ok = !err_q && (skip_q || part_ok);
	assign joined  = {pack_q, acc_q[7:0]};

	always_comb begin
		logic fall;
		phase_n = phase_q;
		base_n  = base_q;
		acc_n   = acc_q;
		seen_n  = seen_q;
		parts_n = parts_q;
		pack_n  = pack_q;
		err_n   = err_q;
		skip_n  = skip_q;
		fall    = 1'b0;
		if (pop) begin
			if (head_tok.term) begin
				phase_n = PH_START;
				base_n  = BASE_DEC;
				acc_n   = '0;
				seen_n  = 1'b0;
				parts_n = '0;
				pack_n  = '0;
				err_n   = 1'b0;
				skip_n  = 1'b0;
			end else if (!err_q && !skip_q) begin
				unique case (phase_q)
					PH_START: begin
						if (head_tok.zero) begin
							seen_n  = 1'b1;
							base_n  = BASE_OCT;
							phase_n = PH_ZERO;
						end else if (head_tok.x) begin
							base_n  = BASE_HEX;
							phase_n = PH_DIGITS;
						end else begin
							phase_n = PH_DIGITS;
							fall    = 1'b1;
						end
					end
					PH_ZERO: begin
						phase_n = PH_DIGITS;
						if (head_tok.x) begin
							base_n = BASE_HEX;
						end else begin
							fall = 1'b1;
						end
					end
					default: fall = 1'b1;
				endcase
				if (fall) begin
					if (head_tok.dec) begin
						if ((base_q == BASE_OCT) && head_tok.digit[3]) begin
							err_n = 1'b1;   // 8 or 9 in an octal part
						end else begin
							acc_n  = acc_step;
							seen_n = 1'b1;
						end
					end else if ((base_q == BASE_HEX) && head_tok.hexl) begin
						acc_n  = acc_step;
						seen_n = 1'b1;
					end else if (!part_ok) begin
						err_n = 1'b1;
					end else if (head_tok.dot) begin
						pack_n  = joined[PACK_W-1:0];
						parts_n = CNT_W'(parts_q + 1'b1);
						phase_n = PH_START;
						base_n  = BASE_DEC;
						acc_n   = '0;
						seen_n  = 1'b0;
					end else if (head_tok.space) begin
						skip_n = 1'b1;
					end else begin
						err_n = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			base_q      <= BASE_DEC;
			acc_q       <= '0;
			seen_q      <= 1'b0;
			parts_q     <= '0;
			pack_q      <= '0;
			err_q       <= 1'b0;
			skip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_n;
			base_q  <= base_n;
			acc_q   <= acc_n;
			seen_q  <= seen_n;
			parts_q <= parts_n;
			pack_q  <= pack_n;
			err_q   <= err_n;
			skip_q  <= skip_n;
			if (pop && head_tok.term) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_tok.term) begin
			res_valid_q <= term_ok;
			res_net_q   <= term_ok ? NET_W'(joined) : NET_ERR;
			res_cnt_q   <= term_ok ? CNT_W'(parts_q + 1'b1) : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - NET_W - CNT_W){1'b0}}, res_cnt_q, res_net_q};

endmodule

// ===== src/dotted_network_number_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dotted_network_number_parser: streaming parser for dotted network numbers
// Characters in, one packed network number out per zero-terminated string.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one character per request in s_tdata[7:0]; a zero byte ends
//     the string. Parts are decimal, octal (leading 0) or hex (x/X prefix),
//     dot separated, each at most 255; whitespace ends the parse.
//   m_* channel: one request per string, sent at its zero byte.
//     m_tdata[31:0] is the value packed big-endian and right aligned,
//     m_tdata[34:32] the part count, m_tuser the valid flag. On an error the
//     value is all ones and the count zero.
//   Throughput: one character per cycle while the queue is not full. A
//     character is written into the token queue before the parse engine
//     takes it, and a result is registered when its zero byte is popped.
//   Stall: a result waits in the output register; the engine keeps taking
//     characters until the next zero byte, which waits at the queue head.
//     The queue (QUEUE_DEPTH tokens) then fills and drops s_tready.
//   Reset: arst_n clears queue, parse state and output valid; the first
//     character after reset starts a new string.
// ----------------------------------------------------------------------------
module dotted_network_number_parser
	import dnp_pkg::*;
#(
	parameter int MAX_PARTS   = MAX_PARTS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [CHAR_W-1:0]      s_tdata,    // [7:0] char_code
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,    // [31:0] net_value, [34:32] part_count
	output logic                   m_tuser     // [0] valid_res
);

	dnp_token_t push_tok;   // classified character from the front
	dnp_token_t head_tok;   // oldest token in the queue
	dnp_qstat_t qstat;
	logic       push;
	logic       pop;

	// front: classify the incoming character
	dnp_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.qstat    (qstat),
		.push     (push),
		.token    (push_tok)
	);

	// queue decouples input acceptance from result back-pressure
	dnp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tok (push_tok),
		.pop      (pop),
		.head_tok (head_tok),
		.qstat    (qstat)
	);

	// back: parse state machine and output register
	dnp_back #(
		.MAX_PARTS (MAX_PARTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_tok (head_tok),
		.qstat    (qstat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== src/dnp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnp_checker: port-level checks of the parser
// Result encoding and output hold under stall.
// ----------------------------------------------------------------------------
module dnp_checker
	import dnp_pkg::*;
#(
	parameter int MAX_PARTS = MAX_PARTS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata[NET_W-1:0] == NET_ERR)
			&& (m_tdata[NET_W+CNT_W-1:NET_W] == '0))
		else $error("error result not encoded as all ones with zero count");

	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[NET_W+CNT_W-1:NET_W] != '0)
			&& (m_tdata[NET_W+CNT_W-1:NET_W] <= CNT_W'(MAX_PARTS)))
		else $error("valid result with bad part count");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_TDATA_W-1:NET_W+CNT_W] == '0))
		else $error("tdata padding not zero");

endmodule

bind dotted_network_number_parser dnp_checker #(
	.MAX_PARTS (MAX_PARTS)
) u_dnp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
